[src/sha1_pkg.sv]
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared types and constants of the byte stream SHA-1 hasher: command and
// status codes, sequencer states, initial hash and round constants.
// ----------------------------------------------------------------------------
package sha1_pkg;

  typedef enum logic [1:0] {
    CMD_ABSORB  = 2'd0,
    CMD_FINISH  = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK           = 2'd0,
    STAT_TOO_LONG     = 2'd1,
    STAT_AFTER_FINISH = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_ROUND,
    S_UPDATE,
    S_EMIT
  } state_t;

  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
  localparam logic [31:0] H2_INIT = 32'h98BADCFE;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

  localparam logic [31:0] K_CH  = 32'h5A827999;
  localparam logic [31:0] K_P1  = 32'h6ED9EBA1;
  localparam logic [31:0] K_MAJ = 32'h8F1BBCDC;
  localparam logic [31:0] K_P2  = 32'hCA62C1D6;

  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam logic [6:0] ROUND_P1_START  = 7'd20;
  localparam logic [6:0] ROUND_MAJ_START = 7'd40;
  localparam logic [6:0] ROUND_P2_START  = 7'd60;
  localparam logic [6:0] ROUND_LAST      = 7'd79;

  localparam logic [5:0] FILL_LAST = 6'd63;

endpackage

[src/sha1_in_if.sv]
// ----------------------------------------------------------------------------
// sha1_in_if
// Request channel of the hasher: command and message byte with valid/ready.
// ----------------------------------------------------------------------------
interface sha1_in_if import sha1_pkg::*; ();

  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] message_byte;

  modport source (output valid, output command, output message_byte, input ready);
  modport sink   (input valid, input command, input message_byte, output ready);

endinterface

[src/sha1_out_if.sv]
// ----------------------------------------------------------------------------
// sha1_out_if
// Result channel of the hasher: status and five digest words with valid/ready.
// ----------------------------------------------------------------------------
interface sha1_out_if import sha1_pkg::*; ();

  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] digest_word_0;
  logic [31:0] digest_word_1;
  logic [31:0] digest_word_2;
  logic [31:0] digest_word_3;
  logic [31:0] digest_word_4;

  modport source (
    output valid, output status,
    output digest_word_0, output digest_word_1, output digest_word_2,
    output digest_word_3, output digest_word_4,
    input  ready
  );
  modport sink (
    input  valid, input status,
    input  digest_word_0, input digest_word_1, input digest_word_2,
    input  digest_word_3, input digest_word_4,
    output ready
  );

endinterface

[src/sha1_byte_stream_hasher.sv]
// Absorb request: accepted in the idle state; the 64th byte of a block starts a compression
// (80 rounds through the single round adder, then a chain update).
// Finish request: acceptance, one pad byte per cycle up to the block end, one or two
// compressions, then the emit state; a repeated or error finish goes from acceptance
// straight to the emit state. Emit waits while the previous result is unread.
// Not ready meanwhile; the result is registered. Synchronous active-low reset loads the
// initial hash; the byte buffer has none.
// ----------------------------------------------------------------------------
// sha1_byte_stream_hasher
// SHA-1 hasher over a byte stream: a 512-bit shift line collects the block
// and later serves as the message schedule window for the round sequencer.
// ----------------------------------------------------------------------------
module sha1_byte_stream_hasher import sha1_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  sha1_in_if.sink    in_chan,
  sha1_out_if.source out_chan
);

  state_t        state_r, state_nxt;
  logic [511:0]  buf_r, buf_nxt;
  logic [5:0]    fill_r, fill_nxt;
  logic [63:0]   bitlen_r, bitlen_nxt;
  logic          fin_r, fin_nxt;
  status_t       err_r, err_nxt;
  logic          pad_r, pad_nxt;
  logic          mark_r, mark_nxt;
  logic          lenblk_r, lenblk_nxt;
  logic [6:0]    round_r, round_nxt;
  logic [31:0]   a_r, b_r, c_r, d_r, e_r;
  logic [31:0]   a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  logic [31:0]   h_r [5];
  logic [31:0]   h_nxt [5];
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [31:0]   dig_r [5];
  logic [31:0]   dig_nxt [5];

  logic          in_acc;
  logic          out_load;
  logic          wr_en;
  logic [7:0]    wr_byte;
  logic [63:0]   bitlen_inc;
  logic [31:0]   f_val, k_val, t_val, w_new;

  assign in_chan.ready          = (state_r == S_IDLE);
  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = out_status_r;
  assign out_chan.digest_word_0 = dig_r[0];
  assign out_chan.digest_word_1 = dig_r[1];
  assign out_chan.digest_word_2 = dig_r[2];
  assign out_chan.digest_word_3 = dig_r[3];
  assign out_chan.digest_word_4 = dig_r[4];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          case (in_chan.command)
            CMD_ABSORB: begin
              if (err_r == STAT_OK && !fin_r && fill_r == FILL_LAST) begin
                state_nxt = S_ROUND;
              end
            end
            CMD_FINISH: begin
              if (err_r != STAT_OK || fin_r) begin
                state_nxt = S_EMIT;
              end else begin
                state_nxt = S_PAD;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_PAD: begin
        if (fill_r == FILL_LAST) begin
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: begin
        if (round_r == ROUND_LAST) begin
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (!pad_r) begin
          state_nxt = S_IDLE;
        end else if (lenblk_r) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_PAD;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_chan.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_acc   = (state_r == S_IDLE) && in_chan.valid;
    out_load = (state_r == S_EMIT) && (!out_valid_r || out_chan.ready);
    wr_en    = 1'b0;
    wr_byte  = in_chan.message_byte;
    case (state_r)
      S_IDLE: begin
        wr_en = in_acc && (in_chan.command == CMD_ABSORB) && (err_r == STAT_OK) && !fin_r;
      end
      S_PAD: begin
        wr_en = 1'b1;
        if (mark_r) begin
          wr_byte = PAD_MARK;
        end else if (lenblk_r && fill_r[5:3] == 3'b111) begin
          wr_byte = bitlen_r[63:56];
        end else begin
          wr_byte = 8'h00;
        end
      end
      default: wr_en = 1'b0;
    endcase
  end

  // round function
  always_comb begin
    if (round_r < ROUND_P1_START) begin
      f_val = (b_r & c_r) | (~b_r & d_r);
      k_val = K_CH;
    end else if (round_r < ROUND_MAJ_START) begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = K_P1;
    end else if (round_r < ROUND_P2_START) begin
      f_val = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k_val = K_MAJ;
    end else begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = K_P2;
    end
    t_val = {a_r[26:0], a_r[31:27]} + f_val + e_r + buf_r[511:480] + k_val;
    w_new = buf_r[95:64] ^ buf_r[255:224] ^ buf_r[447:416] ^ buf_r[511:480];
    w_new = {w_new[30:0], w_new[31]};
  end

  // datapath next values
  always_comb begin
    buf_nxt        = buf_r;
    fill_nxt       = fill_r;
    bitlen_nxt     = bitlen_r;
    fin_nxt        = fin_r;
    err_nxt        = err_r;
    pad_nxt        = pad_r;
    mark_nxt       = mark_r;
    lenblk_nxt     = lenblk_r;
    round_nxt      = round_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    c_nxt          = c_r;
    d_nxt          = d_r;
    e_nxt          = e_r;
    h_nxt          = h_r;
    out_status_nxt = out_status_r;
    dig_nxt        = dig_r;
    out_valid_nxt  = out_valid_r;
    bitlen_inc     = bitlen_r + 64'd8;

    if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_chan.command)
            CMD_ABSORB: begin
              if (err_r == STAT_OK) begin
                if (fin_r) begin
                  err_nxt = STAT_AFTER_FINISH;
                end else begin
                  bitlen_nxt = bitlen_inc;
                  if (bitlen_inc == 64'd0) begin
                    err_nxt = STAT_TOO_LONG;
                  end
                end
              end
            end
            CMD_FINISH: begin
              if (err_r == STAT_OK && !fin_r) begin
                pad_nxt  = 1'b1;
                mark_nxt = 1'b1;
              end
            end
            CMD_RESTART: begin
              h_nxt[0]   = H0_INIT;
              h_nxt[1]   = H1_INIT;
              h_nxt[2]   = H2_INIT;
              h_nxt[3]   = H3_INIT;
              h_nxt[4]   = H4_INIT;
              fill_nxt   = 6'd0;
              bitlen_nxt = 64'd0;
              fin_nxt    = 1'b0;
              err_nxt    = STAT_OK;
              pad_nxt    = 1'b0;
              mark_nxt   = 1'b0;
            end
            default: fill_nxt = fill_r;
          endcase
        end
      end
      S_PAD: begin
        if (mark_r) begin
          mark_nxt   = 1'b0;
          lenblk_nxt = (fill_r[5:3] != 3'b111);
        end else if (lenblk_r && fill_r[5:3] == 3'b111) begin
          bitlen_nxt = {bitlen_r[55:0], 8'h00};
        end
      end
      S_ROUND: begin
        a_nxt     = t_val;
        b_nxt     = a_r;
        c_nxt     = {b_r[1:0], b_r[31:2]};
        d_nxt     = c_r;
        e_nxt     = d_r;
        buf_nxt   = {buf_r[479:0], w_new};
        round_nxt = round_r + 7'd1;
      end
      S_UPDATE: begin
        h_nxt[0] = h_r[0] + a_r;
        h_nxt[1] = h_r[1] + b_r;
        h_nxt[2] = h_r[2] + c_r;
        h_nxt[3] = h_r[3] + d_r;
        h_nxt[4] = h_r[4] + e_r;
        if (pad_r) begin
          if (lenblk_r) begin
            fin_nxt = 1'b1;
            pad_nxt = 1'b0;
          end else begin
            lenblk_nxt = 1'b1;
          end
        end
      end
      S_EMIT: begin
        if (out_load) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = err_r;
          for (int i = 0; i < 5; i++) begin
            dig_nxt[i] = (err_r == STAT_OK) ? h_r[i] : 32'd0;
          end
        end
      end
      default: round_nxt = round_r;
    endcase

    if (wr_en) begin
      buf_nxt  = {buf_r[503:0], wr_byte};
      fill_nxt = fill_r + 6'd1;
      if (fill_r == FILL_LAST) begin
        a_nxt     = h_r[0];
        b_nxt     = h_r[1];
        c_nxt     = h_r[2];
        d_nxt     = h_r[3];
        e_nxt     = h_r[4];
        round_nxt = 7'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= 6'd0;
      bitlen_r    <= 64'd0;
      fin_r       <= 1'b0;
      err_r       <= STAT_OK;
      pad_r       <= 1'b0;
      mark_r      <= 1'b0;
      lenblk_r    <= 1'b0;
      round_r     <= 7'd0;
      out_valid_r <= 1'b0;
      h_r[0]      <= H0_INIT;
      h_r[1]      <= H1_INIT;
      h_r[2]      <= H2_INIT;
      h_r[3]      <= H3_INIT;
      h_r[4]      <= H4_INIT;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      bitlen_r    <= bitlen_nxt;
      fin_r       <= fin_nxt;
      err_r       <= err_nxt;
      pad_r       <= pad_nxt;
      mark_r      <= mark_nxt;
      lenblk_r    <= lenblk_nxt;
      round_r     <= round_nxt;
      out_valid_r <= out_valid_nxt;
      h_r         <= h_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r        <= buf_nxt;
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    c_r          <= c_nxt;
    d_r          <= d_nxt;
    e_r          <= e_nxt;
    out_status_r <= out_status_nxt;
    dig_r        <= dig_nxt;
  end

endmodule

[dv/tb_sha1_byte_stream_hasher.sv]
// ----------------------------------------------------------------------------
// tb_sha1_byte_stream_hasher
// Self-checking bench for the byte stream SHA-1 hasher. A behavioral SHA-1
// model tracks every accepted request and queues the digest that each finish
// must return. A monitor compares each returned digest field by field. Random
// gaps on the request side and random stalls on the digest side are used,
// along with a long digest hold-off, a drain pause and full-rate stretches.
// ----------------------------------------------------------------------------
module tb_sha1_byte_stream_hasher;
  timeunit 1ns;
  timeprecision 1ps;
  import sha1_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 250;
  localparam int RANDOM_TARGET  = 250;

  typedef struct packed {
    logic [1:0]       status;
    logic [4:0][31:0] word;
  } digest_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sha1_in_if  in_chan();
  sha1_out_if out_chan();

  sha1_byte_stream_hasher DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #1 clk = ~clk;

  // model state
  logic [31:0] hash_q [5];
  logic [7:0]  blk_q [64];
  int unsigned fill_q;
  logic [63:0] bits_q;
  bit          done_q;
  logic [1:0]  err_q;

  digest_t     pending_digests [$];
  int unsigned effective_requests = 0;
  int unsigned finishes_sent = 0;
  int unsigned digests_checked = 0;
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  int          rx_long_hold = 0;
  int          rx_wait = 0;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void sha1_compress();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++)
      w[i] = {blk_q[4*i], blk_q[4*i+1], blk_q[4*i+2], blk_q[4*i+3]};
    for (int i = 16; i < 80; i++)
      w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = hash_q[0]; b = hash_q[1]; c = hash_q[2]; d = hash_q[3]; e = hash_q[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d); k = K_CH;
      end else if (i < 40) begin
        f = b ^ c ^ d; k = K_P1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d); k = K_MAJ;
      end else begin
        f = b ^ c ^ d; k = K_P2;
      end
      t = rotl(a, 5) + f + e + w[i] + k;
      e = d; d = c; c = rotl(b, 30); b = a; a = t;
    end
    hash_q[0] += a; hash_q[1] += b; hash_q[2] += c; hash_q[3] += d; hash_q[4] += e;
    fill_q = 0;
  endfunction

  function automatic void hasher_restart();
    hash_q[0] = H0_INIT; hash_q[1] = H1_INIT; hash_q[2] = H2_INIT;
    hash_q[3] = H3_INIT; hash_q[4] = H4_INIT;
    fill_q = 0;
    bits_q = '0;
    done_q = 1'b0;
    err_q  = STAT_OK;
  endfunction

  function automatic void pad_message();
    blk_q[fill_q] = PAD_MARK;
    fill_q++;
    if (fill_q > 56) begin
      while (fill_q < 64) begin
        blk_q[fill_q] = 8'h00;
        fill_q++;
      end
      sha1_compress();
    end
    while (fill_q < 56) begin
      blk_q[fill_q] = 8'h00;
      fill_q++;
    end
    for (int i = 0; i < 8; i++)
      blk_q[56+i] = bits_q[63-8*i -: 8];
    sha1_compress();
    bits_q = '0;
    done_q = 1'b1;
  endfunction

  // advances the model by one request; returns 1 when a digest is due
  function automatic bit predict_request(input logic [1:0] cmd, input logic [7:0] data,
                                         output digest_t res, output bit counts);
    bit has_res;
    has_res = 1'b0;
    counts  = 1'b1;
    res     = '0;
    case (cmd)
      CMD_ABSORB: begin
        if (err_q != STAT_OK) begin
          counts = 1'b0;
        end else if (done_q) begin
          err_q = STAT_AFTER_FINISH;
        end else begin
          blk_q[fill_q] = data;
          fill_q++;
          bits_q += 64'd8;
          if (bits_q == '0) err_q = STAT_TOO_LONG;
          if (fill_q >= 64) sha1_compress();
        end
      end
      CMD_FINISH: begin
        has_res = 1'b1;
        res.status = err_q;
        if (err_q == STAT_OK) begin
          if (!done_q) pad_message();
          for (int j = 0; j < 5; j++) res.word[j] = hash_q[j];
        end
      end
      CMD_RESTART: hasher_restart();
      default: counts = 1'b0;
    endcase
    return has_res;
  endfunction

  task automatic send_request(input logic [1:0] cmd, input logic [7:0] data);
    int      gap;
    digest_t res;
    bit      counts;
    gap = tx_idle_en ? int'($urandom_range(15, 0)) : 0;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.command      <= cmd;
    in_chan.message_byte <= data;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    if (predict_request(cmd, data, res, counts)) begin
      pending_digests.push_back(res);
      finishes_sent++;
    end
    if (counts) effective_requests++;
  endtask

  task automatic wait_for_digests();
    in_chan.valid <= 1'b0;
    while (pending_digests.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_message(input int len);
    int noise;
    noise = $urandom_range(9, 0);
    // noise 0: no restart, so bytes land on a finished message
    if (noise != 0) send_request(CMD_RESTART, 8'($urandom));
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(31, 0) == 0) send_request(CMD_UNUSED, 8'($urandom));
      if (noise == 1 && i == len / 2) send_request(CMD_RESTART, 8'($urandom));
      send_request(CMD_ABSORB, 8'($urandom));
    end
    send_request(CMD_FINISH, 8'($urandom));
    if (noise == 2) send_request(CMD_FINISH, 8'($urandom));
  endtask

  function automatic int pick_length();
    int lens [9] = '{0, 55, 56, 57, 63, 64, 65, 119, 120};
    if ($urandom_range(3, 0) == 0) return lens[$urandom_range(8, 0)];
    return $urandom_range(12, 0);
  endfunction

  task automatic test_directed_cases();
    send_request(CMD_FINISH, 8'h00);
    send_request(CMD_FINISH, 8'hFF);
    send_request(CMD_RESTART, 8'hFF);
    send_request(CMD_ABSORB, 8'h61);
    send_request(CMD_ABSORB, 8'h62);
    send_request(CMD_UNUSED, 8'hA5);
    send_request(CMD_ABSORB, 8'h63);
    send_request(CMD_FINISH, 8'h5A);
    send_request(CMD_ABSORB, 8'hFF);
    send_request(CMD_ABSORB, 8'h00);
    send_request(CMD_FINISH, 8'h00);
    send_request(CMD_FINISH, 8'h00);
    send_request(CMD_RESTART, 8'h00);
    send_request(CMD_ABSORB, 8'h12);
    send_request(CMD_RESTART, 8'h34);
    send_request(CMD_ABSORB, 8'h00);
    send_request(CMD_ABSORB, 8'hFF);
    send_request(CMD_FINISH, 8'h00);
    send_request(CMD_RESTART, 8'h00);
    send_request(CMD_FINISH, 8'h00);
  endtask

  task automatic test_random_messages();
    int unsigned start;
    start = effective_requests;
    while (effective_requests - start < RANDOM_TARGET)
      send_random_message(pick_length());
  endtask

  task automatic test_output_backpressure();
    tx_idle_en = 1'b0;
    rx_long_hold = HOLD_CYCLES;
    repeat (4) send_random_message($urandom_range(8, 1));
    tx_idle_en = 1'b1;
  endtask

  task automatic test_drain_pause();
    repeat (3) begin
      send_random_message(pick_length());
      wait_for_digests();
      repeat (DRAIN_CYCLES) @(posedge clk);
    end
  endtask

  task automatic test_full_rate();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_random_message(64);
    send_random_message(10);
    send_random_message(56);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // digest monitor and ready driver
  always @(posedge clk) begin : digest_monitor
    digest_t          exp;
    logic [4:0][31:0] got;
    if (rst_n) begin
      if (out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
        got = {out_chan.digest_word_4, out_chan.digest_word_3, out_chan.digest_word_2,
               out_chan.digest_word_1, out_chan.digest_word_0};
        if (pending_digests.size() == 0) begin
          $display("%0t: digest with none expected, status %h word0 %h",
                   $time, out_chan.status, got[0]);
          error_count++;
        end else begin
          exp = pending_digests.pop_front();
          digests_checked++;
          if (out_chan.status !== exp.status) begin
            $display("%0t: status expected %h actual %h", $time, exp.status, out_chan.status);
            error_count++;
          end
          for (int j = 0; j < 5; j++)
            if (got[j] !== exp.word[j]) begin
              $display("%0t: digest word %0d expected %h actual %h",
                       $time, j, exp.word[j], got[j]);
              error_count++;
            end
        end
        rx_wait = rx_idle_en ? int'($urandom_range(15, 0)) : 0;
      end
      if (rx_long_hold > 0) begin
        rx_wait = rx_long_hold;
        rx_long_hold = 0;
      end
      if (rx_wait > 0) begin
        out_chan.ready <= 1'b0;
        rx_wait--;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_chan.valid === 1'b1 && in_chan.ready === 1'b1) ||
        (out_chan.valid === 1'b1 && out_chan.ready === 1'b1))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no request or digest moved for %0d cycles", $time, idle_cycles);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    in_chan.valid        = 1'b0;
    in_chan.command      = CMD_ABSORB;
    in_chan.message_byte = 8'h00;
    out_chan.ready       = 1'b0;
    hasher_restart();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_random_messages();
    test_output_backpressure();
    test_drain_pause();
    test_full_rate();

    wait_for_digests();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d effective requests and %0d finish requests", effective_requests,
             finishes_sent);
    $display("%0d digests compared, with gaps, stalls, a long hold-off and pad boundaries",
             digests_checked);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
src/sha1_pkg.sv
src/sha1_in_if.sv
src/sha1_out_if.sv
src/sha1_byte_stream_hasher.sv
dv/tb_sha1_byte_stream_hasher.sv
